/* hdl/sfit_pkg.sv */
`default_nettype none
package sfit_pkg;

  // Table geometry
  localparam int TableDepth = 64;
  localparam int KeyBytes   = 8;
  localparam int KeyW       = 64;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);

  // Fixed field widths of the ports
  localparam int SymW   = 7;
  localparam int LimitW = 7;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(TableDepth);
  localparam logic [SymW-1:0]   NoIndex    = '1;

  // Search item walking down the cell row
  typedef struct packed {
    logic            valid;
    logic            is_sym;
    logic            last;
    logic [KeyW-1:0] key;
    logic [IdxW-1:0] pos;
    logic [CntW-1:0] count;
    logic [CntW-1:0] searched;
    logic            fit;
    logic            hit;
    logic            newly;
    logic [IdxW-1:0] idx;
  } token_t;

  // One finished answer
  typedef struct packed {
    logic [SymW-1:0] sym_idx;
    logic            newly;
    logic            full;
    logic [SymW-1:0] ucount;
    logic            done;
  } result_t;

  // Keep the low KeyBytes bytes up to the first zero byte, clear the rest
  function automatic logic [KeyW-1:0] normalize_key(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] res;
    logic            alive;
    res   = '0;
    alive = 1'b1;
    for (int b = 0; b < KeyW / 8; b++) begin
      if (b >= KeyBytes || k[8*b +: 8] == 8'h00) begin
        alive = 1'b0;
      end
      if (alive) begin
        res[8*b +: 8] = k[8*b +: 8];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* hdl/sfit_cell.sv */
`default_nettype none
module sfit_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sfit_pkg::token_t tok_i,
  output sfit_pkg::token_t tok_o
);
  import sfit_pkg::*;

  logic [KeyW-1:0] key_q;
  token_t          tok_d;
  token_t          tok_q;
  logic            vld_q;
  logic            cmp_en;
  logic            match;
  logic            store;

  // Compare against the held key, or claim this slot on a miss
  always_comb begin
    cmp_en = tok_i.valid && tok_i.is_sym && (tok_i.key != '0) && !tok_i.hit && !tok_i.newly;
    match  = cmp_en && (CntW'(tok_i.pos) < tok_i.searched) && (key_q == tok_i.key);
    store  = cmp_en && (CntW'(tok_i.pos) == tok_i.count) && tok_i.fit;

    tok_d       = tok_i;
    tok_d.pos   = tok_i.pos + IdxW'(1);
    tok_d.hit   = tok_i.hit | match;
    tok_d.newly = tok_i.newly | store;
    if (match || store) begin
      tok_d.idx = tok_i.pos;
    end
  end

  // Write the key when this slot is claimed
  always_ff @(posedge clk_i) begin
    if (store) begin
      key_q <= tok_i.key;
    end
  end

  // Advance the item payload to the neighbor
  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.valid;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = vld_q;
  end

endmodule
`default_nettype wire

/* hdl/sfit_resq.sv */
`default_nettype none
module sfit_resq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sfit_pkg::result_t res_i,
  input  logic              pop_i,
  output sfit_pkg::result_t res_o,
  output logic              valid_o,
  output logic              full_o
);
  import sfit_pkg::*;

  result_t    ent_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign do_pop  = pop_i && valid_o;
  assign res_o   = ent_q[rd_q];

  // Hold results until taken
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/symbol_find_or_insert_table.sv */
// Channel | Handshake                        | Carries
// --------+----------------------------------+------------------------------------------
// in      | in_valid_i / in_stall_o          | start_new, is_symbol, key, last_token
// out     | out_valid_o / out_stall_i        | symbol_index, newly_stored, table_full,
//         |                                  | unique_count, list_done
// cfg     | cfg_valid_i / cfg_ready_o        | table_limit
//
// Each item walks the row of TableDepth cells, one cell per cycle; its result is pushed into
// the result queue as it leaves the row, and the next item is taken only after that, so the
// row holds one item at a time.
// Reset empties the table (count zero) and sets table_limit to TableDepth; no clearing pass.
// Results wait in a two-entry queue; input stalls while an item walks the row or the
// queue is full. A stalled output never blocks the row.
`default_nettype none
module symbol_find_or_insert_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         start_new_i,
  input  logic                         is_symbol_i,
  input  logic [63:0]                  key_i,
  input  logic                         last_token_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [6:0]            symbol_index_o,
  output logic                         newly_stored_o,
  output logic                         table_full_o,
  output logic [6:0]                   unique_count_o,
  output logic                         list_done_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sfit_pkg::LimitW-1:0]  cfg_table_limit_i
);
  import sfit_pkg::*;

  logic [LimitW-1:0] limit_q;
  logic [CntW-1:0]   count_q;
  logic              busy_q;
  logic              in_acc;
  logic [CntW-1:0]   cnt_now;
  logic [CntW-1:0]   lim;
  token_t            chain [TableDepth+1];
  token_t            tail;
  result_t           res;
  result_t           head;
  logic              q_full;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q || q_full;
  assign in_acc      = in_valid_i && !in_stall_o;

  // Clamp the limit and form the launch item
  always_comb begin
    cnt_now = start_new_i ? '0 : count_q;
    if (int'(limit_q) > TableDepth) begin
      lim = CntW'(TableDepth);
    end else begin
      lim = CntW'(limit_q);
    end
    chain[0].valid    = in_acc;
    chain[0].is_sym   = is_symbol_i;
    chain[0].last     = last_token_i;
    chain[0].key      = normalize_key(key_i);
    chain[0].pos      = '0;
    chain[0].count    = cnt_now;
    chain[0].searched = (cnt_now < lim) ? cnt_now : lim;
    chain[0].fit      = (cnt_now < lim);
    chain[0].hit      = 1'b0;
    chain[0].newly    = 1'b0;
    chain[0].idx      = '0;
  end

  // Row of cells, one slot each
  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    sfit_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

  assign tail = chain[TableDepth];

  // Build the answer from the item leaving the row
  always_comb begin
    res.newly  = 1'b0;
    res.full   = 1'b0;
    res.done   = tail.last;
    res.ucount = SymW'(tail.count + CntW'(tail.newly));
    if (!tail.is_sym) begin
      res.sym_idx = NoIndex;
    end else if (tail.hit || tail.newly) begin
      res.sym_idx = SymW'(tail.idx);
      res.newly   = tail.newly;
    end else if (tail.fit) begin
      res.sym_idx = SymW'(tail.count);
    end else begin
      res.sym_idx = NoIndex;
      res.full    = 1'b1;
    end
  end

  sfit_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tail.valid),
    .res_i   (res),
    .pop_i   (!out_stall_i),
    .res_o   (head),
    .valid_o (out_valid_o),
    .full_o  (q_full)
  );

  assign symbol_index_o = head.sym_idx;
  assign newly_stored_o = head.newly;
  assign table_full_o   = head.full;
  assign unique_count_o = head.ucount;
  assign list_done_o    = head.done;

  // Track the item in flight, the fill count and the limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
      count_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_table_limit_i;
      end
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (tail.valid) begin
        busy_q <= 1'b0;
      end
      if (in_acc && start_new_i) begin
        count_q <= '0;
      end else if (tail.valid) begin
        count_q <= tail.count + CntW'(tail.newly);
      end
    end
  end

  a_tail_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> busy_q)
    else $error("item left the row with none in flight");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> !q_full)
    else $error("result pushed into full queue");

  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth))
    else $error("fill count beyond table depth");

  a_new_or_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(newly_stored_o && table_full_o))
    else $error("result both stored and full");

endmodule
`default_nettype wire
